/* hw/rtl/lseacc_pkg.sv */
`timescale 1ns / 1ps

package lseacc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SUM_WIDTH = 32;
   localparam int VAL_W     = FRAC_BITS + 10;
   localparam int SUM_FRAC  = SUM_WIDTH - 16;
   localparam int Q2S_SH    = 32 - SUM_FRAC;
   localparam int NORM_W    = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;
   localparam int P_W       = $clog2(SUM_WIDTH);
   localparam int D_W       = FRAC_BITS + 5;
   localparam int MAG_W     = VAL_W + 24;
   localparam int T_W       = 22;
   localparam int LG_W      = 28;
   localparam int LN_W      = LG_W + 30;
   localparam int R_W       = FRAC_BITS + 4;

   localparam logic [VAL_W-1:0] VAL_MAX_U = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN_U = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [SUM_WIDTH-1:0] SUM_ONE = SUM_WIDTH'(1) << SUM_FRAC;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};
   localparam logic [D_W:0] EXP_CAP = (D_W + 1)'(23) << FRAC_BITS;
   localparam logic signed [9:0] SH_BIAS = 10'(FRAC_BITS - 150);
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam int EXP_STEPS = 16;
   localparam int LOG_STEPS = 24;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD       = 2'd1,
      STATUS_NO_FINITE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_FINITE,
      KIND_BAD,
      KIND_NEG_INF
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_CLASS,
      ST_EXP_MUL,
      ST_EXP_SQ,
      ST_EXP_SHIFT,
      ST_ACC_ADD,
      ST_ACC_MUL,
      ST_ACC_MADD,
      ST_CHECK,
      ST_NORM_LOAD,
      ST_NORM,
      ST_LOG_SQ,
      ST_LOG_MUL,
      ST_LOG_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       convert;
      logic       classify;
      logic       exp_mul;
      logic       exp_sq;
      logic       exp_shift;
      logic       acc_add;
      logic       acc_mul;
      logic       acc_madd;
      logic       norm_load;
      logic       norm_step;
      logic       log_sq;
      logic       log_mul;
      logic       log_add;
      logic       emit;
      logic [4:0] step;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     any_finite;
      logic     bad_seen;
      logic     x_gt;
      logic     is_last;
      logic     norm_done;
      logic     out_free;
   } stat_type;

   typedef logic [31:0] pow_tab_type [17];

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] num;
      logic [63:0] res;
      logic [63:0] bitv;
      num  = n;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > num) bitv = bitv >> 2;
      while (bitv != 64'd0) begin
         if (num >= res + bitv) begin
            num = num - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Entry i holds 2^(-2^-i) in Q32, built by repeated square roots from one half.
   function automatic pow_tab_type build_pow_tab();
      pow_tab_type tab;
      tab[0] = 32'h8000_0000;
      for (int i = 1; i < 17; i++) begin
         tab[i] = 32'(isqrt64({tab[i-1], 32'd0}));
      end
      return tab;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

endpackage

/* hw/rtl/lseacc_req_if.sv */
`timescale 1ns / 1ps

interface lseacc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] logit_bits;
   logic        is_last;

   modport source (output valid, output logit_bits, output is_last, input ready);
   modport sink (input valid, input logit_bits, input is_last, output ready);
endinterface

/* hw/rtl/lseacc_rsp_if.sv */
`timescale 1ns / 1ps

interface lseacc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lseacc_pkg::VAL_W-1:0] log_norm;
   logic [1:0]                          status;

   modport source (output valid, output log_norm, output status, input ready);
   modport sink (input valid, input log_norm, input status, output ready);
endinterface

/* hw/rtl/lseacc_ctrl.sv */
`timescale 1ns / 1ps

module lseacc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lseacc_pkg::stat_type stat,
   output lseacc_pkg::cmd_type  cmd
);

   lseacc_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lseacc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lseacc_pkg::ST_IDLE: begin
            if (req_valid) state_in = lseacc_pkg::ST_CONV;
         end
         lseacc_pkg::ST_CONV: state_in = lseacc_pkg::ST_CLASS;
         lseacc_pkg::ST_CLASS: begin
            if (stat.kind == lseacc_pkg::KIND_FINITE && stat.any_finite) begin
               state_in = lseacc_pkg::ST_EXP_MUL;
            end else begin
               state_in = lseacc_pkg::ST_CHECK;
            end
         end
         lseacc_pkg::ST_EXP_MUL: state_in = lseacc_pkg::ST_EXP_SQ;
         lseacc_pkg::ST_EXP_SQ: begin
            if (cnt_ff == 5'(lseacc_pkg::EXP_STEPS - 1)) state_in = lseacc_pkg::ST_EXP_SHIFT;
         end
         lseacc_pkg::ST_EXP_SHIFT: begin
            state_in = stat.x_gt ? lseacc_pkg::ST_ACC_MUL : lseacc_pkg::ST_ACC_ADD;
         end
         lseacc_pkg::ST_ACC_ADD: state_in = lseacc_pkg::ST_CHECK;
         lseacc_pkg::ST_ACC_MUL: state_in = lseacc_pkg::ST_ACC_MADD;
         lseacc_pkg::ST_ACC_MADD: state_in = lseacc_pkg::ST_CHECK;
         lseacc_pkg::ST_CHECK: begin
            if (!stat.is_last) begin
               state_in = lseacc_pkg::ST_IDLE;
            end else if (stat.bad_seen || !stat.any_finite) begin
               state_in = lseacc_pkg::ST_EMIT;
            end else begin
               state_in = lseacc_pkg::ST_NORM_LOAD;
            end
         end
         lseacc_pkg::ST_NORM_LOAD: state_in = lseacc_pkg::ST_NORM;
         lseacc_pkg::ST_NORM: begin
            if (stat.norm_done) state_in = lseacc_pkg::ST_LOG_SQ;
         end
         lseacc_pkg::ST_LOG_SQ: begin
            if (cnt_ff == 5'(lseacc_pkg::LOG_STEPS - 1)) state_in = lseacc_pkg::ST_LOG_MUL;
         end
         lseacc_pkg::ST_LOG_MUL: state_in = lseacc_pkg::ST_LOG_ADD;
         lseacc_pkg::ST_LOG_ADD: state_in = lseacc_pkg::ST_EMIT;
         lseacc_pkg::ST_EMIT: begin
            if (stat.out_free) state_in = lseacc_pkg::ST_IDLE;
         end
         default: state_in = lseacc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = '0;
      if ((state_ff == lseacc_pkg::ST_EXP_SQ && state_in == lseacc_pkg::ST_EXP_SQ) ||
          (state_ff == lseacc_pkg::ST_LOG_SQ && state_in == lseacc_pkg::ST_LOG_SQ)) begin
         cnt_in = cnt_ff + 5'd1;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.step  = cnt_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         lseacc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lseacc_pkg::ST_CONV:      cmd.convert   = 1'b1;
         lseacc_pkg::ST_CLASS:     cmd.classify  = 1'b1;
         lseacc_pkg::ST_EXP_MUL:   cmd.exp_mul   = 1'b1;
         lseacc_pkg::ST_EXP_SQ:    cmd.exp_sq    = 1'b1;
         lseacc_pkg::ST_EXP_SHIFT: cmd.exp_shift = 1'b1;
         lseacc_pkg::ST_ACC_ADD:   cmd.acc_add   = 1'b1;
         lseacc_pkg::ST_ACC_MUL:   cmd.acc_mul   = 1'b1;
         lseacc_pkg::ST_ACC_MADD:  cmd.acc_madd  = 1'b1;
         lseacc_pkg::ST_CHECK:     cmd.step      = cnt_ff;
         lseacc_pkg::ST_NORM_LOAD: cmd.norm_load = 1'b1;
         lseacc_pkg::ST_NORM:      cmd.norm_step = 1'b1;
         lseacc_pkg::ST_LOG_SQ:    cmd.log_sq    = 1'b1;
         lseacc_pkg::ST_LOG_MUL:   cmd.log_mul   = 1'b1;
         lseacc_pkg::ST_LOG_ADD:   cmd.log_add   = 1'b1;
         lseacc_pkg::ST_EMIT:      cmd.emit      = stat.out_free;
         default:                  cmd.step      = cnt_ff;
      endcase
   end

endmodule

/* hw/rtl/lseacc_dpath.sv */
`timescale 1ns / 1ps

module lseacc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  lseacc_pkg::cmd_type                 cmd,
   output lseacc_pkg::stat_type                stat,
   input  logic [31:0]                         req_logit_bits,
   input  logic                                req_is_last,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [lseacc_pkg::VAL_W-1:0] rsp_log_norm,
   output logic [1:0]                          rsp_status
);

   localparam int VW = lseacc_pkg::VAL_W;
   localparam int SW = lseacc_pkg::SUM_WIDTH;
   localparam int FB = lseacc_pkg::FRAC_BITS;
   localparam int MW = lseacc_pkg::MAG_W;
   localparam int NW = lseacc_pkg::NORM_W;

   // Control state.
   logic [VW-1:0]        max_ff, max_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic                 any_ff, any_in;
   logic                 bad_ff, bad_in;
   logic                 valid_ff, valid_in;

   // Payload registers.
   logic [31:0]          raw_ff;
   logic                 last_ff;
   logic [VW-1:0]        x_ff;
   lseacc_pkg::kind_type kind_ff;
   logic                 gt_ff;
   logic                 big_ff;
   logic [VW:0]          d_ff;
   logic [lseacc_pkg::T_W-1:0] t_ff;
   logic [32:0]          y_ff;
   logic [SW+32:0]       prod_ff;
   logic [NW-1:0]        w_ff;
   logic [lseacc_pkg::P_W-1:0] p_ff;
   logic [31:0]          z_ff;
   logic [23:0]          frac_ff;
   logic [lseacc_pkg::LN_W-1:0] lnprod_ff;
   logic [VW-1:0]        res_ff;
   logic [VW-1:0]        out_norm_ff;
   logic [1:0]           out_status_ff;

   // Float to fixed conversion.
   logic                 sgn;
   logic [7:0]           expo;
   logic [22:0]          frac_m;
   logic [23:0]          mant;
   logic signed [9:0]    sh;
   logic signed [9:0]    neg_sh;
   logic [MW-1:0]        mag;
   logic [24:0]          rnd;
   logic [VW-1:0]        conv_x;
   lseacc_pkg::kind_type conv_kind;

   always_comb begin
      sgn    = raw_ff[31];
      expo   = raw_ff[30:23];
      frac_m = raw_ff[22:0];
      mant   = {expo != 8'd0, frac_m};
      sh     = $signed({2'b00, (expo == 8'd0) ? 8'd1 : expo}) + lseacc_pkg::SH_BIAS;
      neg_sh = -sh;
      rnd    = ({1'b0, mant} >> (neg_sh[4:0] - 5'd1)) + 25'd1;
      if (mant == 24'd0) begin
         mag = '0;
      end else if (sh >= 10'sd0) begin
         if (sh >= 10'(VW)) mag = MW'(1) << VW;
         else mag = MW'(mant) << sh[5:0];
      end else if (neg_sh > 10'sd25) begin
         mag = '0;
      end else begin
         mag = MW'(rnd >> 1);
      end
      if (sgn) begin
         conv_x = (mag > (MW'(1) << (VW - 1))) ? lseacc_pkg::VAL_MIN_U : (VW'(0) - mag[VW-1:0]);
      end else begin
         conv_x = (mag > MW'(lseacc_pkg::VAL_MAX_U)) ? lseacc_pkg::VAL_MAX_U : mag[VW-1:0];
      end
      if (expo == 8'hFF) begin
         conv_kind = (frac_m != 23'd0 || !sgn) ? lseacc_pkg::KIND_BAD : lseacc_pkg::KIND_NEG_INF;
      end else begin
         conv_kind = lseacc_pkg::KIND_FINITE;
      end
   end

   // Arithmetic for the recurrence and the final log.
   logic [VW:0]          diff;
   logic                 x_gt_max;
   logic [FB+36:0]       tsum;
   logic [5:0]           k;
   logic [15:0]          f;
   logic [4:0]           tab_idx;
   logic [64:0]          yprod;
   logic [33:0]          yshr;
   logic [33:0]          term2;
   logic [SW:0]          add_sum;
   logic [SW+33:0]       mround;
   logic [SW+1:0]        madd;
   logic [63:0]          zsq;
   logic [32:0]          zs;
   logic [lseacc_pkg::P_W-1:0] pdiff;
   logic [lseacc_pkg::LG_W-1:0] lg;
   logic [lseacc_pkg::LN_W:0] lnsum;
   logic [lseacc_pkg::R_W-1:0] r;
   logic signed [VW:0]   res;

   always_comb begin
      x_gt_max = $signed(x_ff) > $signed(max_ff);
      if (x_gt_max) diff = {x_ff[VW-1], x_ff} - {max_ff[VW-1], max_ff};
      else diff = {max_ff[VW-1], max_ff} - {x_ff[VW-1], x_ff};
      tsum    = (FB+37)'(d_ff[lseacc_pkg::D_W-1:0]) * (FB+37)'(lseacc_pkg::LOG2E_Q30)
                + ((FB+37)'(1) << (FB + 13));
      k       = t_ff[21:16];
      f       = t_ff[15:0];
      tab_idx = cmd.step + 5'd1;
      yprod   = 65'(y_ff) * 65'(lseacc_pkg::POW_TAB[tab_idx]) + (65'(1) << 31);
      if (k == 6'd0) yshr = {1'b0, y_ff};
      else if (k >= 6'd40) yshr = '0;
      else yshr = (({1'b0, y_ff} >> (k - 6'd1)) + 34'd1) >> 1;
      term2   = ((({1'b0, y_ff, 1'b0} >> lseacc_pkg::Q2S_SH)) + 35'd1) >> 1 > 0 ?
                34'(((({1'b0, y_ff, 1'b0} >> lseacc_pkg::Q2S_SH)) + 35'd1) >> 1) : '0;
      add_sum = {1'b0, sum_ff} + (SW+1)'(term2);
      mround  = {1'b0, prod_ff} + ((SW+34)'(1) << 31);
      madd    = (SW+2)'(mround >> 32) + (SW+2)'(lseacc_pkg::SUM_ONE);
      zsq     = 64'(z_ff) * 64'(z_ff);
      zs      = zsq[63:31];
      pdiff   = p_ff - lseacc_pkg::P_W'(lseacc_pkg::SUM_FRAC);
      lg      = {pdiff[3:0], frac_ff};
      lnsum   = {1'b0, lnprod_ff} + ((lseacc_pkg::LN_W+1)'(1) << (53 - FB));
      r       = lnsum[54-FB +: lseacc_pkg::R_W];
      res     = $signed({max_ff[VW-1], max_ff}) + $signed((VW+1)'(r));
   end

   always_comb begin
      max_in   = max_ff;
      sum_in   = sum_ff;
      any_in   = any_ff;
      bad_in   = bad_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (cmd.classify) begin
         if (kind_ff == lseacc_pkg::KIND_BAD) bad_in = 1'b1;
         if (kind_ff == lseacc_pkg::KIND_FINITE && !any_ff) begin
            max_in = x_ff;
            sum_in = lseacc_pkg::SUM_ONE;
            any_in = 1'b1;
         end
      end
      if (cmd.acc_add) begin
         sum_in = add_sum[SW] ? lseacc_pkg::SUM_MAX : add_sum[SW-1:0];
      end
      if (cmd.acc_madd) begin
         sum_in = (madd > (SW+2)'(lseacc_pkg::SUM_MAX)) ? lseacc_pkg::SUM_MAX : madd[SW-1:0];
         max_in = x_ff;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         max_in   = lseacc_pkg::VAL_MIN_U;
         sum_in   = '0;
         any_in   = 1'b0;
         bad_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= lseacc_pkg::VAL_MIN_U;
         sum_ff   <= '0;
         any_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         any_ff   <= any_in;
         bad_ff   <= bad_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff  <= req_logit_bits;
         last_ff <= req_is_last;
      end
      if (cmd.convert) begin
         x_ff    <= conv_x;
         kind_ff <= conv_kind;
      end
      if (cmd.classify) begin
         gt_ff  <= x_gt_max;
         d_ff   <= diff;
         big_ff <= diff >= lseacc_pkg::EXP_CAP;
      end
      if (cmd.exp_mul) begin
         t_ff <= tsum[FB+14 +: lseacc_pkg::T_W];
         y_ff <= 33'h1_0000_0000;
      end
      if (cmd.exp_sq && f[4'd15 - cmd.step[3:0]]) begin
         y_ff <= yprod[64:32];
      end
      if (cmd.exp_shift) begin
         y_ff <= big_ff ? 33'd0 : yshr[32:0];
      end
      if (cmd.acc_mul) begin
         prod_ff <= (SW+33)'(sum_ff) * (SW+33)'(y_ff);
      end
      if (cmd.norm_load) begin
         w_ff <= NW'(sum_ff) << (NW - SW);
         p_ff <= lseacc_pkg::P_W'(SW - 1);
      end
      if (cmd.norm_step) begin
         if (stat.norm_done) begin
            z_ff    <= w_ff[NW-1 -: 32];
            frac_ff <= '0;
         end else begin
            w_ff <= w_ff << 1;
            p_ff <= p_ff - lseacc_pkg::P_W'(1);
         end
      end
      if (cmd.log_sq) begin
         if (zs[32]) begin
            z_ff    <= zs[32:1];
            frac_ff <= {frac_ff[22:0], 1'b1};
         end else begin
            z_ff    <= zs[31:0];
            frac_ff <= {frac_ff[22:0], 1'b0};
         end
      end
      if (cmd.log_mul) begin
         lnprod_ff <= lseacc_pkg::LN_W'(lg) * lseacc_pkg::LN_W'(lseacc_pkg::LN2_Q30);
      end
      if (cmd.log_add) begin
         res_ff <= (res > $signed({1'b0, lseacc_pkg::VAL_MAX_U})) ?
                   lseacc_pkg::VAL_MAX_U : res[VW-1:0];
      end
      if (cmd.emit) begin
         if (bad_ff) begin
            out_norm_ff   <= '0;
            out_status_ff <= lseacc_pkg::STATUS_BAD;
         end else if (!any_ff) begin
            out_norm_ff   <= '0;
            out_status_ff <= lseacc_pkg::STATUS_NO_FINITE;
         end else begin
            out_norm_ff   <= res_ff;
            out_status_ff <= lseacc_pkg::STATUS_OK;
         end
      end
   end

   always_comb begin
      stat.kind       = kind_ff;
      stat.any_finite = any_ff;
      stat.bad_seen   = bad_ff;
      stat.x_gt       = gt_ff;
      stat.is_last    = last_ff;
      stat.norm_done  = w_ff[NW-1] || (p_ff == '0);
      stat.out_free   = !valid_ff || rsp_ready;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_log_norm = $signed(out_norm_ff);
   assign rsp_status   = out_status_ff;

endmodule

/* hw/rtl/logsumexp_accumulator_unit.sv */
`timescale 1ns / 1ps

// Log-sum-exp over a vector of float32 logits delivered one transaction at a time, with
// the last logit of each vector marked. Finite logits become signed Q10.16 and feed an
// online recurrence (running maximum plus a rescaled exponential sum); negative infinity
// is skipped, NaN or positive infinity gives status 1, and a vector with no finite logit
// gives status 2. One item is processed at a time in a shared exponential and log unit.
// A non-finite item or a vector's first finite logit runs convert, classify and check;
// a later finite logit also runs the exponential (a multiply, 16 table steps, a shift) and
// an add or a multiply-add. A last item with an error status then goes to emit; otherwise
// it runs a load, up to 16 normalize steps, 24 log squaring steps, a multiply, an add and
// emit. The result sits in an output register, so the next transaction is accepted while
// it waits; a last item that finds the previous result waiting holds until it is taken.

module logsumexp_accumulator_unit (
   input logic           clock,
   input logic           reset,
   lseacc_req_if.sink    req_chan,
   lseacc_rsp_if.source  rsp_chan
);

   lseacc_pkg::cmd_type  cmd;
   lseacc_pkg::stat_type stat;
   logic                 req_ready;

   lseacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lseacc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_logit_bits (req_chan.logit_bits),
      .req_is_last    (req_chan.is_last),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_log_norm   (rsp_chan.log_norm),
      .rsp_status     (rsp_chan.status)
   );

   assign req_chan.ready = req_ready;

endmodule

/* hw/rtl/lseacc_checker.sv */
`timescale 1ns / 1ps

module lseacc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lseacc_pkg::VAL_W-1:0] rsp_log_norm,
   input logic [1:0]                          rsp_status
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result appeared right after reset.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == lseacc_pkg::STATUS_OK ||
                     rsp_status == lseacc_pkg::STATUS_BAD ||
                     rsp_status == lseacc_pkg::STATUS_NO_FINITE))
      else $error("A result carries an unused status code.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lseacc_pkg::STATUS_OK) |-> rsp_log_norm == '0)
      else $error("An error result carries a nonzero value.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_log_norm) && $stable(rsp_status)))
      else $error("A stalled result transaction changed.");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A transaction was accepted while the previous one was in work.");

endmodule

bind logsumexp_accumulator_unit lseacc_checker u_lseacc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_log_norm (rsp_chan.log_norm),
   .rsp_status   (rsp_chan.status)
);
